// ===== rtl/assert_macros.svh =====
// Assertion macros for the debouncer RTL.
// No dependencies; included inside module bodies that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check clocked on a rising edge, muted while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error(msg);

// Same check, never muted.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/bdhr_pkg.sv =====
// Package for the button debouncer: register map, reset values, shared structs.
// No dependencies.
`default_nettype none

package bdhr_pkg;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam int CFG_W  = 16;

	// register index = paddr[4:2]
	localparam logic [2:0] REG_ENABLED     = 3'd0;
	localparam logic [2:0] REG_ACTIVE_LVL  = 3'd1;
	localparam logic [2:0] REG_PRESS_DB    = 3'd2;
	localparam logic [2:0] REG_RELEASE_DB  = 3'd3;
	localparam logic [2:0] REG_HOLD_IV     = 3'd4;

	localparam logic             RST_ENABLED    = 1'b1;
	localparam logic             RST_ACTIVE_LVL = 1'b0;
	localparam logic [CFG_W-1:0] RST_PRESS_DB   = 16'd50;
	localparam logic [CFG_W-1:0] RST_RELEASE_DB = 16'd50;
	localparam logic [CFG_W-1:0] RST_HOLD_IV    = 16'd1000;

	typedef struct packed {
		logic             enabled;
		logic             active_level;
		logic [CFG_W-1:0] press_debounce_ms;
		logic [CFG_W-1:0] release_debounce_ms;
		logic [CFG_W-1:0] hold_interval_ms;
	} cfg_t;

	typedef struct packed {
		logic pressed_state;
		logic release_event;
		logic hold_event;
		logic press_event;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/bdhr_core.sv =====
// Debounce state: held flag, three saturating tick counters, event decisions.
// Depends on bdhr_pkg and assert_macros.svh. State advances on each step.
`default_nettype none

module bdhr_core #(
	parameter int TIMER_WIDTH = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire logic             pin_level,
	input  wire bdhr_pkg::cfg_t   cfg,
	output bdhr_pkg::result_t     res
);
	import bdhr_pkg::*;
	`include "assert_macros.svh"

	// compare width covers both the counters and the 16-bit thresholds
	localparam int CMP_W = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;
	localparam logic [TIMER_WIDTH-1:0] TMAX = '1;

	logic                   held_q;
	logic [TIMER_WIDTH-1:0] since_press_q, since_release_q, since_impulse_q;

	logic [TIMER_WIDTH-1:0] press_inc, release_inc, impulse_inc, impulse_nx;
	logic [TIMER_WIDTH-1:0] press_nx, release_nx;
	logic [CMP_W-1:0]       press_x, release_x, impulse_x;
	logic [CMP_W-1:0]       th_press, th_release, th_hold;
	logic                   held_nx, ev_press, ev_hold, ev_release, active;

	always_comb begin
		press_inc   = (since_press_q   == TMAX) ? TMAX : since_press_q   + 1'b1;
		release_inc = (since_release_q == TMAX) ? TMAX : since_release_q + 1'b1;
		impulse_inc = (since_impulse_q == TMAX) ? TMAX : since_impulse_q + 1'b1;

		active     = cfg.enabled && (pin_level == cfg.active_level);
		impulse_nx = active ? '0 : impulse_inc;

		press_x    = CMP_W'(press_inc);
		release_x  = CMP_W'(release_inc);
		impulse_x  = CMP_W'(impulse_nx);
		th_press   = CMP_W'(cfg.press_debounce_ms);
		th_release = CMP_W'(cfg.release_debounce_ms);
		th_hold    = CMP_W'(cfg.hold_interval_ms);

		ev_press   = 1'b0;
		ev_hold    = 1'b0;
		ev_release = 1'b0;
		press_nx   = press_inc;
		release_nx = release_inc;
		held_nx    = held_q;

		if (cfg.enabled) begin
			if (!held_q) begin
				if (release_x > th_press && impulse_x < th_press) begin
					ev_press = 1'b1;
					press_nx = '0;
					held_nx  = 1'b1;
				end
			end else if (press_x > th_release) begin
				if (press_x > th_hold) begin
					ev_hold  = 1'b1;
					press_nx = '0;
				end
				if (impulse_x > th_press) begin
					ev_release = 1'b1;
					press_nx   = '0;
					release_nx = '0;
					held_nx    = 1'b0;
				end
			end
		end

		res.press_event   = ev_press;
		res.hold_event    = ev_hold;
		res.release_event = ev_release;
		res.pressed_state = held_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q          <= 1'b0;
			since_press_q   <= '0;
			since_release_q <= TMAX;
			since_impulse_q <= TMAX;
		end else if (step) begin
			held_q          <= held_nx;
			since_press_q   <= press_nx;
			since_release_q <= release_nx;
			since_impulse_q <= impulse_nx;
		end
	end

	`ASSERT_CLK(a_press_from_released, clk, arst_n,
		step && res.press_event |-> !held_q && !res.release_event,
		"press fired while already held")
	`ASSERT_CLK(a_frozen_when_disabled, clk, arst_n,
		step && !cfg.enabled |=> held_q == $past(held_q),
		"held flag moved while disabled")
	`ASSERT_CLK(a_event_restarts_timer, clk, arst_n,
		step && (res.press_event || res.hold_event || res.release_event) |=>
			since_press_q == '0,
		"press timer not restarted by event")
	`ASSERT_CLK(a_release_clears_timer, clk, arst_n,
		step && res.release_event |=> since_release_q == '0 && !held_q,
		"release did not restart release timer")

endmodule

`default_nettype wire

// ===== rtl/button_debounce_hold_repeat.sv =====
// Channel   | Dir | tdata bits                          | tuser
// s_*       | in  | [0] pin_level                       | -
// m_*       | out | [0] press [1] hold [2] release [3] pressed_state | -
// APB       | cfg | 5 regs at 4*i: enabled, active_level, press/release debounce, hold interval
//
// One tick per cycle sustained while the master side accepts results; a tick waits in the
// input register and its result is registered in the output register when the tick advances.
// bdhr_core updates its counters and runs the threshold compares on each step.
// Reset: released, press timer zero, release and impulse timers saturated.
// A stalled master side holds the result; the input register keeps one more beat.
// Depends on bdhr_pkg and bdhr_core.
`default_nettype none

module button_debounce_hold_repeat #(
	parameter int TIMER_WIDTH = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [7:0]                    s_tdata,  // [0] pin_level, [7:1] zero
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [7:0]                         m_tdata,  // [0] press_event [1] hold_event
	                                                     // [2] release_event [3] pressed_state
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [bdhr_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [bdhr_pkg::DATA_W-1:0]   pwdata,
	output logic [bdhr_pkg::DATA_W-1:0]       prdata,
	output logic                               pready
);
	import bdhr_pkg::*;

	cfg_t       cfg_q;
	logic       valid_s1, pin_s1;
	logic       out_valid_q;
	result_t    out_q, res;
	logic       advance, wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled             <= RST_ENABLED;
			cfg_q.active_level        <= RST_ACTIVE_LVL;
			cfg_q.press_debounce_ms   <= RST_PRESS_DB;
			cfg_q.release_debounce_ms <= RST_RELEASE_DB;
			cfg_q.hold_interval_ms    <= RST_HOLD_IV;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_ENABLED:    cfg_q.enabled             <= pwdata[0];
				REG_ACTIVE_LVL: cfg_q.active_level        <= pwdata[0];
				REG_PRESS_DB:   cfg_q.press_debounce_ms   <= pwdata[CFG_W-1:0];
				REG_RELEASE_DB: cfg_q.release_debounce_ms <= pwdata[CFG_W-1:0];
				REG_HOLD_IV:    cfg_q.hold_interval_ms    <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_ENABLED:    prdata = DATA_W'(cfg_q.enabled);
			REG_ACTIVE_LVL: prdata = DATA_W'(cfg_q.active_level);
			REG_PRESS_DB:   prdata = DATA_W'(cfg_q.press_debounce_ms);
			REG_RELEASE_DB: prdata = DATA_W'(cfg_q.release_debounce_ms);
			REG_HOLD_IV:    prdata = DATA_W'(cfg_q.hold_interval_ms);
			default:        prdata = '0;
		endcase
	end

	// input beat moves on when the result register is free or draining
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (advance)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			pin_s1 <= s_tdata[0];
		if (advance)
			out_q <= res;
	end

	bdhr_core #(
		.TIMER_WIDTH(TIMER_WIDTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.pin_level (pin_s1),
		.cfg       (cfg_q),
		.res       (res)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, out_q.pressed_state, out_q.release_event,
	                   out_q.hold_event, out_q.press_event};

endmodule

`default_nettype wire

// ===== bench/tb_button_debounce_hold_repeat.sv =====
// Self-checking bench for button_debounce_hold_repeat: directed and random tick streams
// with random idling, checked against an in-bench debouncer predictor.
// Depends on bdhr_pkg and the button_debounce_hold_repeat RTL.
`default_nettype none

module tb_button_debounce_hold_repeat;
	import bdhr_pkg::*;

	localparam int          CYCLE_LIMIT = 1000000;
	localparam logic [15:0] TIMER_MAX   = 16'hFFFF;

	logic        clk     = 1'b0;
	logic        arst_n  = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [ADDR_W-1:0] paddr  = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic        pready;

	// predictor state
	cfg_t        cfg_model;
	logic        held;
	logic [15:0] since_press;
	logic [15:0] since_release;
	logic [15:0] since_impulse;

	result_t     expected_events[$];
	result_t     got_events;
	result_t     want_events;

	int          error_count    = 0;
	int          cycle_count    = 0;
	int          send_idle_pct  = 0;
	int          recv_stall_pct = 0;
	int          recv_hold_left = 0;

	button_debounce_hold_repeat #(.TIMER_WIDTH(16)) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // [0] pin_level, [7:1] zero
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // [0] press [1] hold [2] release [3] pressed_state
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #5 clk = ~clk;

	function automatic logic [15:0] sat_inc(logic [15:0] v);
		return (v == TIMER_MAX) ? TIMER_MAX : v + 16'd1;
	endfunction

	// One millisecond tick of the debouncer.
	function automatic result_t debounce_tick(logic pin);
		result_t r;
		r = '0;
		since_press   = sat_inc(since_press);
		since_release = sat_inc(since_release);
		since_impulse = sat_inc(since_impulse);
		if (cfg_model.enabled) begin
			if (pin == cfg_model.active_level)
				since_impulse = 16'd0;
			if (!held) begin
				if (since_release > cfg_model.press_debounce_ms &&
				    since_impulse < cfg_model.press_debounce_ms) begin
					since_press = 16'd0;
					held = 1'b1;
					r.press_event = 1'b1;
				end
			end else if (since_press > cfg_model.release_debounce_ms) begin
				if (since_press > cfg_model.hold_interval_ms) begin
					since_press = 16'd0;
					r.hold_event = 1'b1;
				end
				if (since_impulse > cfg_model.press_debounce_ms) begin
					since_press = 16'd0;
					since_release = 16'd0;
					held = 1'b0;
					r.release_event = 1'b1;
				end
			end
		end
		r.pressed_state = held;
		return r;
	endfunction

	function automatic logic [31:0] reg_value(logic [2:0] idx);
		case (idx)
			REG_ENABLED:    return {31'd0, cfg_model.enabled};
			REG_ACTIVE_LVL: return {31'd0, cfg_model.active_level};
			REG_PRESS_DB:   return {16'd0, cfg_model.press_debounce_ms};
			REG_RELEASE_DB: return {16'd0, cfg_model.release_debounce_ms};
			REG_HOLD_IV:    return {16'd0, cfg_model.hold_interval_ms};
			default:        return 32'd0;
		endcase
	endfunction

	function void check_field(string name, logic want, logic got);
		if (want !== got) begin
			$error("%s: expected %0b, got %0b", name, want, got);
			error_count++;
		end
	endfunction

	initial begin
		cfg_model.enabled             = RST_ENABLED;
		cfg_model.active_level        = RST_ACTIVE_LVL;
		cfg_model.press_debounce_ms   = RST_PRESS_DB;
		cfg_model.release_debounce_ms = RST_RELEASE_DB;
		cfg_model.hold_interval_ms    = RST_HOLD_IV;
		held          = 1'b0;
		since_press   = 16'd0;
		since_release = TIMER_MAX;
		since_impulse = TIMER_MAX;
	end

	// Monitor: register writes, accepted ticks, and result beats.
	always @(posedge clk) begin
		if (arst_n) begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_ENABLED:    cfg_model.enabled             = pwdata[0];
					REG_ACTIVE_LVL: cfg_model.active_level        = pwdata[0];
					REG_PRESS_DB:   cfg_model.press_debounce_ms   = pwdata[15:0];
					REG_RELEASE_DB: cfg_model.release_debounce_ms = pwdata[15:0];
					REG_HOLD_IV:    cfg_model.hold_interval_ms    = pwdata[15:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				expected_events.push_back(debounce_tick(s_tdata[0]));
			if (m_tvalid && m_tready) begin
				got_events = result_t'(m_tdata[3:0]);
				if (expected_events.size() == 0) begin
					$error("result beat with no tick pending: tdata %h", m_tdata);
					error_count++;
				end else begin
					want_events = expected_events.pop_front();
					check_field("press_event", want_events.press_event, got_events.press_event);
					check_field("hold_event", want_events.hold_event, got_events.hold_event);
					check_field("release_event", want_events.release_event,
						got_events.release_event);
					check_field("pressed_state", want_events.pressed_state,
						got_events.pressed_state);
				end
			end
		end
	end

	// Receiver: random stalls, plus a counted hold-off when requested.
	always @(negedge clk) begin
		if (recv_hold_left > 0) begin
			recv_hold_left = recv_hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// All tasks start and end on a falling edge.
	task automatic send_tick(logic pin);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, pin};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic send_run(logic pin, int n);
		repeat (n) send_tick(pin);
	endtask

	task automatic send_noise(int n);
		repeat (n) send_tick(1'($urandom));
	endtask

	// Sender pauses until every pending result is back, then lets the pipe settle.
	task automatic drain;
		s_tvalid <= 1'b0;
		while (expected_events.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic apb_transfer(logic wr, logic [2:0] idx, logic [31:0] data,
	                            output logic [31:0] rd);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rd = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_register(logic [2:0] idx, logic [31:0] data);
		logic [31:0] rd;
		apb_transfer(1'b1, idx, data, rd);
		if (idx <= REG_HOLD_IV) begin
			apb_transfer(1'b0, idx, 32'd0, rd);
			if (rd !== reg_value(idx)) begin
				$error("prdata reg %0d: expected %h, got %h", idx, reg_value(idx), rd);
				error_count++;
			end
		end
	endtask

	// Upper bits carry junk; the block keeps only the register's width.
	task automatic set_config(logic en, logic lvl, logic [15:0] pdb, logic [15:0] rdb,
	                          logic [15:0] hiv);
		set_register(REG_ENABLED, {31'($urandom), en});
		set_register(REG_ACTIVE_LVL, {31'($urandom), lvl});
		set_register(REG_PRESS_DB, {16'($urandom), pdb});
		set_register(REG_RELEASE_DB, {16'($urandom), rdb});
		set_register(REG_HOLD_IV, {16'($urandom), hiv});
	endtask

	function automatic logic [15:0] pick_timer(int top);
		case ($urandom_range(9))
			0:       return 16'd0;
			1:       return TIMER_MAX;
			2:       return TIMER_MAX - 16'd1;
			default: return 16'($urandom_range(top, 1));
		endcase
	endfunction

	// Timers saturated out of reset: first active sample presses at default settings.
	task automatic test_boot_press;
		send_tick(1'b1);
		send_tick(1'b1);
		send_tick(1'b0);
		drain;
	endtask

	task automatic test_press_hold_release;
		set_config(1'b1, 1'b1, 16'd2, 16'd1, 16'd3);
		send_run(1'b0, 3);
		send_run(1'b1, 8);
		send_run(1'b0, 5);
		drain;
	endtask

	// press 1, release 0, hold 1: hold repeat and release land on the same tick
	task automatic test_hold_with_release;
		set_config(1'b1, 1'b1, 16'd1, 16'd0, 16'd1);
		send_run(1'b0, 3);
		send_tick(1'b1);
		send_run(1'b0, 2);
		drain;
	endtask

	// Disabled: no events, held flag frozen, active samples do not refresh the impulse timer.
	task automatic test_disabled;
		set_config(1'b1, 1'b0, 16'd1, 16'd0, 16'd100);
		send_run(1'b1, 3);
		send_tick(1'b0);
		drain;
		set_register(REG_ENABLED, 32'd0);
		send_run(1'b1, 3);
		send_tick(1'b0);
		drain;
		set_register(REG_ENABLED, 32'd1);
		send_run(1'b1, 3);
		drain;
	endtask

	task automatic test_unknown_register;
		logic [31:0] rd;
		apb_transfer(1'b1, 3'd5, $urandom, rd);
		apb_transfer(1'b1, 3'd6, $urandom, rd);
		apb_transfer(1'b1, 3'd7, 32'hFFFF_FFFF, rd);
		set_register(REG_PRESS_DB, 32'd1);
		send_run(1'b1, 2);
		drain;
	endtask

	// Thresholds at the counter maximum never trip; smaller ones do.
	task automatic test_timer_saturation;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		set_config(1'b1, 1'b1, 16'd1, 16'd0, TIMER_MAX);
		send_run(1'b0, 6);
		send_tick(1'b1);
		drain;
		set_register(REG_PRESS_DB, {16'd0, TIMER_MAX});
		send_run(1'b1, 40);
		send_run(1'b0, 4);
		drain;
		set_register(REG_HOLD_IV, 32'd2);
		send_run(1'b1, 6);
		drain;
		set_register(REG_PRESS_DB, 32'd0);
		send_run(1'b0, 3);
		drain;
	endtask

	// Long receiver hold-off while ticks keep coming: input side must stall.
	task automatic test_backpressure;
		set_config(1'b1, 1'b0, 16'd2, 16'd1, 16'd4);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		recv_hold_left = 200;
		send_noise(40);
		drain;
	endtask

	task automatic send_press_cycle(int lim, output int n);
		int b1, act, b2, quiet;
		b1    = $urandom_range(3, 0);
		act   = $urandom_range(3 * lim + 4, 1);
		b2    = $urandom_range(3, 0);
		quiet = $urandom_range(2 * lim + 4, 1);
		send_noise(b1);
		send_run(cfg_model.active_level, act);
		send_noise(b2);
		send_run(~cfg_model.active_level, quiet);
		n = b1 + act + b2 + quiet;
	endtask

	task automatic test_random_phase(int phase);
		int sent, n, lim;
		case (phase % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
			default: begin send_idle_pct = 22; recv_stall_pct = 22; end
		endcase
		drain;
		set_config(($urandom_range(9) != 0), 1'($urandom), pick_timer(8), pick_timer(8),
			pick_timer(20));
		lim = cfg_model.hold_interval_ms;
		if (cfg_model.press_debounce_ms > lim) lim = cfg_model.press_debounce_ms;
		if (cfg_model.release_debounce_ms > lim) lim = cfg_model.release_debounce_ms;
		if (lim > 25) lim = 25;
		if (lim < 1) lim = 1;
		sent = 0;
		while (sent < 60) begin
			if ($urandom_range(4) == 0) begin
				n = $urandom_range(10, 1);
				send_noise(n);
			end else begin
				send_press_cycle(lim, n);
			end
			sent += n;
		end
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_boot_press;
		test_press_hold_release;
		test_hold_with_release;
		test_disabled;
		test_unknown_register;
		test_timer_saturation;
		test_backpressure;
		for (int p = 0; p < 8; p++)
			test_random_phase(p);
		drain;
		repeat (10) @(negedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/bdhr_pkg.sv
rtl/bdhr_core.sv
rtl/button_debounce_hold_repeat.sv
bench/tb_button_debounce_hold_repeat.sv
